FILE: rtl/mbg_pkg.sv
// shared types, codes and helper functions of the maze backtracker generator
// no dependencies; imported by mbg_chooser, mbg_ctrl and the top level of the block
package mbg_pkg;

    localparam int CFG_W   = 7;
    localparam int COORD_W = 6;
    localparam int SEED_W  = 16;

    // action codes
    localparam logic ACT_GENERATE = 1'b0;
    localparam logic ACT_READ     = 1'b1;

    // register indexes on the configuration port
    localparam logic REG_GRID_WIDTH  = 1'b0;
    localparam logic REG_GRID_HEIGHT = 1'b1;

    // neighbour directions, in probing order
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam logic [SEED_W-1:0] LFSR_ONE = 16'h0001;

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [SEED_W-1:0]  seed;
    } mbg_in_t;

    typedef struct packed {
        logic               right_wall;
        logic               bottom_wall;
        logic               cell_visited;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
    } mbg_out_t;

    // sequencer to chooser
    typedef struct packed {
        logic              load;
        logic              step;
        logic [SEED_W-1:0] seed;
        logic [3:0]        mask;
    } mbg_chs_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_START,
        S_RD_ADDR,
        S_RD_DATA,
        S_PROBE,
        S_DECIDE,
        S_POP_WAIT,
        S_CHOOSE,
        S_CARVE,
        S_RESULT
    } mbg_state_t;

    // fibonacci lfsr, taps 16,14,13,11, new bit in at the top
    function automatic logic [SEED_W-1:0] lfsr_step(input logic [SEED_W-1:0] s);
        logic b;
        b = s[0] ^ s[2] ^ s[3] ^ s[5];
        lfsr_step = {b, s[SEED_W-1:1]};
    endfunction

    // residue mod 3: 4 = 1 and 2 = -1 mod 3, so weight even bits 1 and odd bits 2
    function automatic logic [1:0] mod3_16(input logic [SEED_W-1:0] s);
        logic [3:0] e;
        logic [3:0] o;
        logic [4:0] t;
        e = '0;
        o = '0;
        for (int k = 0; k < SEED_W / 2; k++)
        begin
            e = e + 4'(s[2*k]);
            o = o + 4'(s[2*k+1]);
        end
        t = 5'(e) + {o, 1'b0};
        if (t >= 5'd12)
        begin
            t = t - 5'd12;
        end
        if (t >= 5'd12)
        begin
            t = t - 5'd12;
        end
        if (t >= 5'd6)
        begin
            t = t - 5'd6;
        end
        if (t >= 5'd3)
        begin
            t = t - 5'd3;
        end
        mod3_16 = 2'(t);
    endfunction

    function automatic logic [2:0] popcount4(input logic [3:0] m);
        popcount4 = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    endfunction

    // direction of the idx-th set bit of the candidate mask
    function automatic logic [1:0] pick_dir(input logic [3:0] m, input logic [1:0] idx);
        logic [2:0] seen;
        logic [1:0] d;
        seen = '0;
        d    = DIR_UP;
        for (int k = 0; k < 4; k++)
        begin
            if (m[k])
            begin
                if (seen == {1'b0, idx})
                begin
                    d = 2'(k);
                end
                seen = seen + 3'd1;
            end
        end
        pick_dir = d;
    endfunction

endpackage

FILE: rtl/mbg_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module mbg_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/mbg_chooser.sv
// random neighbour choice: lfsr state and selection among candidate directions
// depends on mbg_pkg
module mbg_chooser
    import mbg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  mbg_chs_t   chs,
    output logic [1:0] dir
);

    logic [SEED_W-1:0] lfsr_reg;
    logic [SEED_W-1:0] lfsr_next;
    logic [2:0]        cand_cnt;
    logic [1:0]        pick_idx;

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (chs.load)
        begin
            // a zero seed would lock the register up
            lfsr_next = (chs.seed == '0) ? LFSR_ONE : chs.seed;
        end
        else if (chs.step)
        begin
            lfsr_next = lfsr_step(lfsr_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_ONE;
        end
        else
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    always_comb
    begin
        cand_cnt = popcount4(chs.mask);
        case (cand_cnt)
            3'd2:    pick_idx = {1'b0, lfsr_reg[0]};
            3'd3:    pick_idx = mod3_16(lfsr_reg);
            3'd4:    pick_idx = lfsr_reg[1:0];
            default: pick_idx = 2'd0;
        endcase
        dir = pick_dir(chs.mask, pick_idx);
    end

    a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        lfsr_reg != '0)
        else $error("lfsr reached the all-zero lock state");

endmodule

FILE: rtl/mbg_ctrl.sv
// sequencer of the maze generator: clearing pass, depth-first carving with a
// shared neighbour address unit, cell reads and the handshake on both sides
// depends on mbg_pkg; drives the cell and stack rams and the chooser
module mbg_ctrl
    import mbg_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [CFG_W-1:0]                grid_width,
    input  logic [CFG_W-1:0]                grid_height,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  mbg_in_t                         item,
    output logic                            res_valid,
    input  logic                            res_take,
    output mbg_out_t                        res,
    output mbg_chs_t                        chs,
    input  logic [1:0]                      chs_dir,
    output logic [2*$clog2(MAX_SIDE)-1:0]   cell_raddr,
    input  logic                            right_rdata,
    input  logic                            bottom_rdata,
    input  logic                            vis_rdata,
    output logic                            right_we,
    output logic [2*$clog2(MAX_SIDE)-1:0]   right_waddr,
    output logic                            right_wdata,
    output logic                            bottom_we,
    output logic [2*$clog2(MAX_SIDE)-1:0]   bottom_waddr,
    output logic                            bottom_wdata,
    output logic                            vis_we,
    output logic [2*$clog2(MAX_SIDE)-1:0]   vis_waddr,
    output logic                            vis_wdata,
    output logic                            stk_we,
    output logic [2*$clog2(MAX_SIDE)-1:0]   stk_waddr,
    output logic [2*$clog2(MAX_SIDE)-1:0]   stk_wdata,
    output logic [2*$clog2(MAX_SIDE)-1:0]   stk_raddr,
    input  logic [2*$clog2(MAX_SIDE)-1:0]   stk_rdata
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DW    = AW + 1;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int CMPW  = (SW > CFG_W) ? SW : CFG_W;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam logic [2:0] PROBE_LAST = 3'd4;

    mbg_state_t   state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          gen_reg, gen_next;
    logic [CW-1:0] px_reg, px_next;
    logic [CW-1:0] py_reg, py_next;
    logic [SW-1:0] w_reg, w_next;
    logic [SW-1:0] h_reg, h_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] last_reg, last_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [2:0]    dir_reg, dir_next;
    logic          inb_reg, inb_next;
    logic [3:0]    mask_reg, mask_next;
    logic [1:0]    sel_dir_reg, sel_dir_next;
    logic          rd_right_reg, rd_right_next;
    logic          rd_bottom_reg, rd_bottom_next;
    logic          rd_vis_reg, rd_vis_next;

    logic          accept;
    logic [SW-1:0] w_eff;
    logic [SW-1:0] h_eff;
    logic [AW-1:0] start_cell;
    logic [1:0]    nb_sel;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [AW-1:0] nb_addr;
    logic          nb_inb;
    logic [1:0]    mask_idx;

    function automatic logic [SW-1:0] eff_side(input logic [CFG_W-1:0] v);
        if (v == '0)
        begin
            eff_side = SW'(1);
        end
        else if (CMPW'(v) > CMPW'(MAX_SIDE))
        begin
            eff_side = SW'(MAX_SIDE);
        end
        else
        begin
            eff_side = SW'(v);
        end
    endfunction

    function automatic logic [CW-1:0] clamp_pos(input logic [COORD_W-1:0] p,
                                                input logic [SW-1:0] s);
        if (CMPW'(p) >= CMPW'(s))
        begin
            clamp_pos = CW'(s - SW'(1));
        end
        else
        begin
            clamp_pos = CW'(p);
        end
    endfunction

    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;
    assign w_eff      = eff_side(grid_width);
    assign h_eff      = eff_side(grid_height);
    assign start_cell = {py_reg, px_reg};
    assign mask_idx   = 2'(dir_reg - 3'd1);

    // shared neighbour unit: probing direction, or the chosen one while carving
    always_comb
    begin
        nb_sel = (state_reg == S_CARVE) ? sel_dir_reg : dir_reg[1:0];
        cx     = cur_reg[CW-1:0];
        cy     = cur_reg[AW-1:CW];
        case (nb_sel)
            DIR_UP:
            begin
                nb_addr = {CW'(cy - CW'(1)), cx};
                nb_inb  = (cy != '0);
            end
            DIR_RIGHT:
            begin
                nb_addr = {cy, CW'(cx + CW'(1))};
                nb_inb  = (SW'(cx) + SW'(1)) < w_reg;
            end
            DIR_DOWN:
            begin
                nb_addr = {CW'(cy + CW'(1)), cx};
                nb_inb  = (SW'(cy) + SW'(1)) < h_reg;
            end
            default:
            begin
                nb_addr = {cy, CW'(cx - CW'(1))};
                nb_inb  = (cx != '0);
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (&clr_reg)
                begin
                    state_next = gen_reg ? S_START : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (item.action == ACT_GENERATE) ? S_CLEAR : S_RD_ADDR;
                end
            end
            S_START:    state_next = S_PROBE;
            S_RD_ADDR:  state_next = S_RD_DATA;
            S_RD_DATA:  state_next = S_RESULT;
            S_PROBE:
            begin
                if (dir_reg == PROBE_LAST)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (mask_reg != '0)
                begin
                    state_next = S_CHOOSE;
                end
                else if (depth_reg == DW'(1))
                begin
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT: state_next = S_PROBE;
            S_CHOOSE:   state_next = S_CARVE;
            S_CARVE:    state_next = S_PROBE;
            S_RESULT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // datapath and ram control
    always_comb
    begin
        clr_next       = clr_reg;
        gen_next       = gen_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        w_next         = w_reg;
        h_next         = h_reg;
        cur_next       = cur_reg;
        last_next      = last_reg;
        depth_next     = depth_reg;
        dir_next       = dir_reg;
        inb_next       = inb_reg;
        mask_next      = mask_reg;
        sel_dir_next   = sel_dir_reg;
        rd_right_next  = rd_right_reg;
        rd_bottom_next = rd_bottom_reg;
        rd_vis_next    = rd_vis_reg;

        cell_raddr   = (state_reg == S_PROBE) ? nb_addr : start_cell;
        stk_raddr    = AW'(depth_reg - DW'(2));
        right_we     = 1'b0;
        right_waddr  = clr_reg;
        right_wdata  = 1'b1;
        bottom_we    = 1'b0;
        bottom_waddr = clr_reg;
        bottom_wdata = 1'b1;
        vis_we       = 1'b0;
        vis_waddr    = clr_reg;
        vis_wdata    = 1'b0;
        stk_we       = 1'b0;
        stk_waddr    = depth_reg[AW-1:0];
        stk_wdata    = nb_addr;

        chs.load = accept && (item.action == ACT_GENERATE);
        chs.step = (state_reg == S_DECIDE) && (mask_reg != '0);
        chs.seed = item.seed;
        chs.mask = mask_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                right_we  = 1'b1;
                bottom_we = 1'b1;
                vis_we    = 1'b1;
                clr_next  = clr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    gen_next = (item.action == ACT_GENERATE);
                    w_next   = w_eff;
                    h_next   = h_eff;
                    px_next  = clamp_pos(item.pos_x, w_eff);
                    py_next  = clamp_pos(item.pos_y, h_eff);
                end
            end
            S_START:
            begin
                vis_we     = 1'b1;
                vis_waddr  = start_cell;
                vis_wdata  = 1'b1;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = start_cell;
                cur_next   = start_cell;
                last_next  = start_cell;
                depth_next = DW'(1);
                dir_next   = '0;
                mask_next  = '0;
            end
            S_RD_ADDR:
            begin
            end
            S_RD_DATA:
            begin
                rd_right_next  = right_rdata;
                rd_bottom_next = bottom_rdata;
                rd_vis_next    = vis_rdata;
            end
            S_PROBE:
            begin
                // read issued for one direction, mark returned for the one before
                if (dir_reg != PROBE_LAST)
                begin
                    inb_next = nb_inb;
                    dir_next = dir_reg + 3'd1;
                end
                if (dir_reg != '0)
                begin
                    mask_next[mask_idx] = inb_reg && !vis_rdata;
                end
            end
            S_DECIDE:
            begin
                if (mask_reg == '0)
                begin
                    depth_next = depth_reg - DW'(1);
                end
            end
            S_POP_WAIT:
            begin
                cur_next  = stk_rdata;
                dir_next  = '0;
                mask_next = '0;
            end
            S_CHOOSE:
            begin
                sel_dir_next = chs_dir;
            end
            S_CARVE:
            begin
                // up and left open the wall stored with the neighbour
                if ((sel_dir_reg == DIR_UP) || (sel_dir_reg == DIR_DOWN))
                begin
                    bottom_we    = 1'b1;
                    bottom_wdata = 1'b0;
                    bottom_waddr = (sel_dir_reg == DIR_UP) ? nb_addr : cur_reg;
                end
                else
                begin
                    right_we    = 1'b1;
                    right_wdata = 1'b0;
                    right_waddr = (sel_dir_reg == DIR_LEFT) ? nb_addr : cur_reg;
                end
                vis_we    = 1'b1;
                vis_waddr = nb_addr;
                vis_wdata = 1'b1;
                if (depth_reg < DW'(CELLS))
                begin
                    stk_we     = 1'b1;
                    depth_next = depth_reg + DW'(1);
                end
                cur_next  = nb_addr;
                last_next = nb_addr;
                dir_next  = '0;
                mask_next = '0;
            end
            S_RESULT:
            begin
            end
        endcase
    end

    always_comb
    begin
        res_valid        = (state_reg == S_RESULT);
        res.right_wall   = !gen_reg && rd_right_reg;
        res.bottom_wall  = !gen_reg && rd_bottom_reg;
        res.cell_visited = !gen_reg && rd_vis_reg;
        res.end_x        = COORD_W'(last_reg[CW-1:0]);
        res.end_y        = COORD_W'(last_reg[AW-1:CW]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            gen_reg     <= 1'b0;
            cur_reg     <= '0;
            last_reg    <= '0;
            depth_reg   <= '0;
            dir_reg     <= '0;
            inb_reg     <= 1'b0;
            mask_reg    <= '0;
            sel_dir_reg <= DIR_UP;
            w_reg       <= SW'(MAX_SIDE);
            h_reg       <= SW'(MAX_SIDE);
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            gen_reg     <= gen_next;
            cur_reg     <= cur_next;
            last_reg    <= last_next;
            depth_reg   <= depth_next;
            dir_reg     <= dir_next;
            inb_reg     <= inb_next;
            mask_reg    <= mask_next;
            sel_dir_reg <= sel_dir_next;
            w_reg       <= w_next;
            h_reg       <= h_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        rd_right_reg  <= rd_right_next;
        rd_bottom_reg <= rd_bottom_next;
        rd_vis_reg    <= rd_vis_next;
    end

    a_carve_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CARVE) |-> mask_reg[sel_dir_reg])
        else $error("carving towards a direction that was not a candidate");

    a_carve_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CARVE) |-> (depth_reg != '0))
        else $error("carving with an empty stack");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(CELLS))
        else $error("stack depth beyond the cell count");

    a_gen_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && gen_reg) |-> (depth_reg == '0))
        else $error("generation result with cells left on the stack");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted transaction did not start work");

endmodule

FILE: rtl/maze_backtracker_generator.sv
// read: cell address, cell data, then the result; one item at a time
// generate: clearing pass over all 2**(2*clog2(MAX_SIDE)) cells (4096 by default), then
//   probe, decide, choose and carve states per carved cell and probe, decide and pop-wait
//   states per pop in the sequencer; the single read port of the visited-mark ram sets the probe time
// reset: registers to 64 x 64, end cell (0,0), then the same clearing pass before
//   the first transaction is taken; configuration writes are taken throughout
// depends on mbg_pkg, mbg_ram, mbg_chooser and mbg_ctrl
module maze_backtracker_generator
    import mbg_pkg::*;
#(
    parameter int MAX_SIDE = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  mbg_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output mbg_out_t    out_data
);

    localparam int AW   = 2 * $clog2(MAX_SIDE);
    localparam int NPOS = 2 ** AW;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             out_valid_reg, out_valid_next;
    mbg_out_t         out_data_reg, out_data_next;

    logic          cfg_wr;
    logic          res_valid;
    logic          res_take;
    mbg_out_t      res;
    mbg_chs_t      chs;
    logic [1:0]    chs_dir;
    logic [AW-1:0] cell_raddr;
    logic          right_rdata;
    logic          bottom_rdata;
    logic          vis_rdata;
    logic          right_we;
    logic [AW-1:0] right_waddr;
    logic          right_wdata;
    logic          bottom_we;
    logic [AW-1:0] bottom_waddr;
    logic          bottom_wdata;
    logic          vis_we;
    logic [AW-1:0] vis_waddr;
    logic          vis_wdata;
    logic          stk_we;
    logic [AW-1:0] stk_waddr;
    logic [AW-1:0] stk_wdata;
    logic [AW-1:0] stk_raddr;
    logic [AW-1:0] stk_rdata;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_GRID_WIDTH:  width_next  = pwdata[CFG_W-1:0];
                REG_GRID_HEIGHT: height_next = pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_GRID_WIDTH:  prdata = 32'(width_reg);
            REG_GRID_HEIGHT: prdata = 32'(height_reg);
        endcase
    end

    // output register parts the sequencer from the consumer
    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (res_take)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= CFG_W'(64);
            height_reg    <= CFG_W'(64);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    mbg_ctrl #(
        .MAX_SIDE(MAX_SIDE)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .grid_width   (width_reg),
        .grid_height  (height_reg),
        .item_valid   (in_valid),
        .item_ready   (in_ready),
        .item         (in_data),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res),
        .chs          (chs),
        .chs_dir      (chs_dir),
        .cell_raddr   (cell_raddr),
        .right_rdata  (right_rdata),
        .bottom_rdata (bottom_rdata),
        .vis_rdata    (vis_rdata),
        .right_we     (right_we),
        .right_waddr  (right_waddr),
        .right_wdata  (right_wdata),
        .bottom_we    (bottom_we),
        .bottom_waddr (bottom_waddr),
        .bottom_wdata (bottom_wdata),
        .vis_we       (vis_we),
        .vis_waddr    (vis_waddr),
        .vis_wdata    (vis_wdata),
        .stk_we       (stk_we),
        .stk_waddr    (stk_waddr),
        .stk_wdata    (stk_wdata),
        .stk_raddr    (stk_raddr),
        .stk_rdata    (stk_rdata)
    );

    mbg_chooser u_chooser (
        .clk   (clk),
        .rst_n (rst_n),
        .chs   (chs),
        .dir   (chs_dir)
    );

    mbg_ram #(
        .WIDTH(1),
        .DEPTH(NPOS)
    ) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .waddr (right_waddr),
        .wdata (right_wdata),
        .raddr (cell_raddr),
        .rdata (right_rdata)
    );

    mbg_ram #(
        .WIDTH(1),
        .DEPTH(NPOS)
    ) u_bottom_ram (
        .clk   (clk),
        .we    (bottom_we),
        .waddr (bottom_waddr),
        .wdata (bottom_wdata),
        .raddr (cell_raddr),
        .rdata (bottom_rdata)
    );

    mbg_ram #(
        .WIDTH(1),
        .DEPTH(NPOS)
    ) u_vis_ram (
        .clk   (clk),
        .we    (vis_we),
        .waddr (vis_waddr),
        .wdata (vis_wdata),
        .raddr (cell_raddr),
        .rdata (vis_rdata)
    );

    mbg_ram #(
        .WIDTH(AW),
        .DEPTH(NPOS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// testbench for maze_backtracker_generator: directed and random generate and read transactions,
// checked against a maze carver kept in the bench; depends on mbg_pkg and the block's rtl
module tb;
    import mbg_pkg::*;

    localparam int SIDE          = 64;
    localparam int CELLS         = SIDE * SIDE;
    localparam int HOLD_LEN      = 40000;
    localparam int IDLE_LIMIT    = 300000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 12;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    mbg_in_t     in_data  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    mbg_out_t    out_data;

    maze_backtracker_generator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // maze state as the block should hold it
    logic [6:0]  grid_w_reg = 7'd64;
    logic [6:0]  grid_h_reg = 7'd64;
    logic        wall_right [CELLS];
    logic        wall_below [CELLS];
    logic        reached    [CELLS];
    int          dfs_stack  [CELLS];
    int          dfs_depth;
    logic [15:0] lfsr_q;
    int          end_cell;

    mbg_in_t     item_queue[$];
    mbg_out_t    expected_results[$];
    mbg_out_t    want_res;

    int tx_gap_max  = 0;
    int rx_gap_max  = 0;
    int tx_wait     = 0;
    int rx_wait     = 0;
    int hold_req    = 0;
    int hold_seen   = 0;
    int mismatches  = 0;
    int idle_cycles = 0;

    function automatic int eff_side(input logic [6:0] v);
        if (v == 7'd0)
        begin
            return 1;
        end
        if (v > 7'(SIDE))
        begin
            return SIDE;
        end
        return int'(v);
    endfunction

    function automatic void carve_maze(input int w, input int h, input int sx, input int sy,
                                       input logic [15:0] seed);
        int         cur;
        int         x;
        int         y;
        int         n;
        int         nxt;
        logic [1:0] cand [4];
        logic [1:0] dir;
        for (int c = 0; c < CELLS; c++)
        begin
            wall_right[c] = 1'b1;
            wall_below[c] = 1'b1;
            reached[c]    = 1'b0;
        end
        lfsr_q   = (seed == 16'd0) ? 16'd1 : seed;
        end_cell = sy * SIDE + sx;
        reached[end_cell] = 1'b1;
        dfs_stack[0] = end_cell;
        dfs_depth    = 1;
        while (dfs_depth > 0)
        begin
            cur = dfs_stack[dfs_depth - 1];
            x   = cur % SIDE;
            y   = cur / SIDE;
            n   = 0;
            // unvisited neighbours, listed up, right, down, left
            if (y > 0 && !reached[cur - SIDE])
            begin
                cand[n] = DIR_UP;
                n++;
            end
            if (x + 1 < w && !reached[cur + 1])
            begin
                cand[n] = DIR_RIGHT;
                n++;
            end
            if (y + 1 < h && !reached[cur + SIDE])
            begin
                cand[n] = DIR_DOWN;
                n++;
            end
            if (x > 0 && !reached[cur - 1])
            begin
                cand[n] = DIR_LEFT;
                n++;
            end
            if (n == 0)
            begin
                dfs_depth--;
            end
            else
            begin
                // taps 16,14,13,11 are bits 0,2,3,5 of a right-shifting register
                lfsr_q = {^(lfsr_q & 16'h002D), lfsr_q[15:1]};
                dir = cand[int'(lfsr_q) % n];
                case (dir)
                    DIR_UP:
                    begin
                        nxt = cur - SIDE;
                        wall_below[nxt] = 1'b0;
                    end
                    DIR_RIGHT:
                    begin
                        nxt = cur + 1;
                        wall_right[cur] = 1'b0;
                    end
                    DIR_DOWN:
                    begin
                        nxt = cur + SIDE;
                        wall_below[cur] = 1'b0;
                    end
                    default:
                    begin
                        nxt = cur - 1;
                        wall_right[nxt] = 1'b0;
                    end
                endcase
                end_cell     = nxt;
                reached[nxt] = 1'b1;
                dfs_stack[dfs_depth] = nxt;
                dfs_depth++;
            end
        end
    endfunction

    function automatic mbg_out_t predict_result(input mbg_in_t item);
        mbg_out_t r;
        int       w;
        int       h;
        int       px;
        int       py;
        int       c;
        w  = eff_side(grid_w_reg);
        h  = eff_side(grid_h_reg);
        px = (int'(item.pos_x) >= w) ? w - 1 : int'(item.pos_x);
        py = (int'(item.pos_y) >= h) ? h - 1 : int'(item.pos_y);
        r  = '0;
        if (item.action == ACT_GENERATE)
        begin
            carve_maze(w, h, px, py, item.seed);
        end
        else
        begin
            c = py * SIDE + px;
            r.right_wall   = wall_right[c];
            r.bottom_wall  = wall_below[c];
            r.cell_visited = reached[c];
        end
        r.end_x = 6'(end_cell % SIDE);
        r.end_y = 6'(end_cell / SIDE);
        return r;
    endfunction

    function automatic int pick_side();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(65, 127);
            2:       return SIDE;
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic queue_item(input logic act, input int x, input int y, input logic [15:0] seed);
        mbg_in_t item;
        item.action = act;
        item.pos_x  = 6'(x);
        item.pos_y  = 6'(y);
        item.seed   = seed;
        item_queue.push_back(item);
    endtask

    task automatic write_reg(input logic idx, input logic [6:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {25'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GRID_WIDTH)
        begin
            grid_w_reg = value;
        end
        else
        begin
            grid_h_reg = value;
        end
    endtask

    // sampled on the falling edge so the driver's updates have settled
    task automatic wait_drained();
        @(negedge clk);
        while (item_queue.size() != 0 || in_valid || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic start_phase(input int w, input int h);
        wait_drained();
        write_reg(REG_GRID_WIDTH, 7'(w));
        write_reg(REG_GRID_HEIGHT, 7'(h));
        @(negedge clk);
    endtask

    // sender: one gap per transaction, drawn once it has gone
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
            begin
                expected_results.push_back(predict_result(in_data));
                tx_wait = $urandom_range(0, tx_gap_max);
            end
            if (tx_wait > 0 || item_queue.size() == 0)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait--;
                end
                in_valid <= 1'b0;
            end
            else
            begin
                in_data  <= item_queue.pop_front();
                in_valid <= 1'b1;
            end
        end
    end

    // receiver: a stall per result, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                rx_wait = $urandom_range(0, rx_gap_max);
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                rx_wait   = HOLD_LEN;
            end
            if (rx_wait > 0)
            begin
                rx_wait--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want_res = expected_results.pop_front();
                if (out_data.right_wall !== want_res.right_wall)
                begin
                    report_mismatch("right_wall", out_data.right_wall, want_res.right_wall);
                end
                if (out_data.bottom_wall !== want_res.bottom_wall)
                begin
                    report_mismatch("bottom_wall", out_data.bottom_wall, want_res.bottom_wall);
                end
                if (out_data.cell_visited !== want_res.cell_visited)
                begin
                    report_mismatch("cell_visited", out_data.cell_visited, want_res.cell_visited);
                end
                if (out_data.end_x !== want_res.end_x)
                begin
                    report_mismatch("end_x", out_data.end_x, want_res.end_x);
                end
                if (out_data.end_y !== want_res.end_y)
                begin
                    report_mismatch("end_y", out_data.end_y, want_res.end_y);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int          w;
        int          h;
        int          ew;
        int          eh;
        int          x;
        int          y;
        logic        act;
        logic [15:0] seed;

        for (int c = 0; c < CELLS; c++)
        begin
            wall_right[c] = 1'b1;
            wall_below[c] = 1'b1;
            reached[c]    = 1'b0;
        end
        lfsr_q    = 16'd1;
        end_cell  = 0;
        dfs_depth = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // untouched maze after reset, then a full-size carve
        queue_item(ACT_READ, 0, 0, 16'hFFFF);
        queue_item(ACT_READ, 63, 63, 16'h0000);
        queue_item(ACT_GENERATE, 63, 63, 16'hFFFF);
        queue_item(ACT_READ, 0, 0, 16'h0000);
        queue_item(ACT_READ, 63, 0, 16'hFFFF);
        queue_item(ACT_READ, 0, 63, 16'h0000);
        queue_item(ACT_READ, 63, 63, 16'hFFFF);

        // single cell, zero seed, start clamped, nothing carved
        start_phase(1, 1);
        queue_item(ACT_GENERATE, 5, 9, 16'h0000);
        queue_item(ACT_READ, 63, 63, 16'h1234);

        // zero-sized grid acts as one cell
        start_phase(0, 0);
        queue_item(ACT_GENERATE, 63, 0, 16'h8000);
        queue_item(ACT_READ, 0, 0, 16'h0000);

        // oversized registers act as the full grid
        start_phase(127, 100);
        queue_item(ACT_GENERATE, 0, 0, 16'h0001);
        queue_item(ACT_READ, 63, 0, 16'h0000);
        queue_item(ACT_READ, 0, 63, 16'h0000);

        start_phase(2, 3);
        queue_item(ACT_GENERATE, 0, 0, 16'h5555);
        queue_item(ACT_READ, 1, 2, 16'h0000);
        queue_item(ACT_READ, 0, 1, 16'h0000);
        queue_item(ACT_READ, 40, 40, 16'h0000);

        start_phase(64, 1);
        queue_item(ACT_GENERATE, 31, 7, 16'hAAAA);
        queue_item(ACT_READ, 0, 0, 16'h0000);

        start_phase(1, 64);
        queue_item(ACT_GENERATE, 7, 0, 16'h7FFF);
        queue_item(ACT_READ, 0, 63, 16'h0000);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            w  = pick_side();
            h  = pick_side();
            // keep carves cheap: at most one long side
            if (eff_side(7'(w)) > 12 && eff_side(7'(h)) > 12)
            begin
                h = $urandom_range(1, 12);
            end
            ew = eff_side(7'(w));
            eh = eff_side(7'(h));
            start_phase(w, h);
            case (p % 4)
                0:
                begin
                    tx_gap_max = 18;
                    rx_gap_max = 18;
                end
                1:
                begin
                    tx_gap_max = 0;
                    rx_gap_max = 0;
                end
                2:
                begin
                    tx_gap_max = 0;
                    rx_gap_max = 18;
                end
                default:
                begin
                    tx_gap_max = 18;
                    rx_gap_max = 0;
                end
            endcase
            // receiver blocks while the sender keeps offering
            if (p == 2)
            begin
                hold_req++;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                act = (i == 0 || $urandom_range(0, 9) < 3) ? ACT_GENERATE : ACT_READ;
                x   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, ew - 1)
                                                  : $urandom_range(0, 63);
                y   = ($urandom_range(0, 3) != 0) ? $urandom_range(0, eh - 1)
                                                  : $urandom_range(0, 63);
                seed = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom);
                queue_item(act, x, y, seed);
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
